@@ sv/bitmap_page_frame_allocator_assert.svh @@
// Assertion macros for the page frame allocator checker.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define BPFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Value must hold into the next cycle while the condition is true.
`define BPFA_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

@@ sv/bpfa_pkg.sv @@
// Shared types, constants and helpers for the page frame allocator.
package bpfa_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 32768;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  typedef enum logic [2:0] {
    ACT_ALLOC    = 3'd0,
    ACT_FREE     = 3'd1,
    ACT_RELEASE  = 3'd2,
    ACT_RESERVE  = 3'd3,
    ACT_SET_FAIL = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_NO_PAGE     = 3'd1,
    STAT_INJECTED    = 3'd2,
    STAT_FREE_RANGE  = 3'd3,
    STAT_FREE_UNUSED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_WORD_RD,
    ST_WORD_MOD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MOD_CLR,
    MOD_SET,
    MOD_ALLOC
  } mod_op_e;

  typedef struct packed {
    mod_op_e     op;
    logic [31:0] old_word;
    logic [4:0]  lo_bit;
    logic [4:0]  last_bit;
    logic        is_first;
    logic        is_last;
  } mod_req_t;

  typedef struct packed {
    logic [31:0] new_word;
    logic [5:0]  delta;
    logic        hit;
    logic [4:0]  bit_idx;
  } mod_res_t;

  // index of the lowest set bit, zero when none
  function automatic logic [4:0] lowest_set(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage

@@ sv/bpfa_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module bpfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bpfa_word_mod.sv @@
// Bit update of one bitmap word: range mask, set/clear/allocate, popcount.
module bpfa_word_mod (
  input  bpfa_pkg::mod_req_t req_i,
  output bpfa_pkg::mod_res_t res_o
);

  logic [31:0] mask;
  logic [31:0] cand;
  logic [31:0] changed;
  logic [4:0]  idx;
  logic [5:0]  pop;

  always_comb begin
    mask = (req_i.is_first ? ({32{1'b1}} << req_i.lo_bit) : {32{1'b1}}) &
           (req_i.is_last ? ({32{1'b1}} >> (5'd31 - req_i.last_bit)) : {32{1'b1}});
    cand = '0;
    idx  = '0;
    case (req_i.op)
      bpfa_pkg::MOD_CLR: changed = req_i.old_word & mask;
      bpfa_pkg::MOD_SET: changed = ~req_i.old_word & mask;
      bpfa_pkg::MOD_ALLOC: begin
        cand    = ~req_i.old_word & mask;
        idx     = bpfa_pkg::lowest_set(cand);
        changed = (|cand) ? (32'd1 << idx) : '0;
      end
      default: changed = '0;
    endcase
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < 32; i++) begin
      pop = pop + 6'(changed[i]);
    end
  end

  always_comb begin
    res_o.new_word = (req_i.op == bpfa_pkg::MOD_CLR) ? (req_i.old_word & ~changed)
                                                     : (req_i.old_word | changed);
    res_o.delta    = pop;
    res_o.hit      = |changed;
    res_o.bit_idx  = idx;
  end

endmodule

@@ sv/bitmap_page_frame_allocator.sv @@
// Bitmap page frame allocator: one used bit per page, held in a single-port
// RAM of 32-bit words, plus a summary RAM with one bit per bitmap word that
// is set while that word has any free page. Every bitmap word touched is
// read and then written back on the RAM port. A free touches one word, a
// release or reserve range touches each word it covers, and an allocate
// first scans the summary words (at most 32 for 32768 pages) for a word
// with a free page, then claims its lowest free page below the page total,
// or ends when the scan finds no candidate word; an injected failure, a set
// failure count, an unknown action, a free out of range and a range that is
// empty or falls outside the page total go from setup straight to the result.
// After reset a clearing pass writes every bitmap word to all used, one word
// a cycle; no request is accepted until it ends, while page_total writes
// are taken at any time. The result sits in an output register, so the
// next request is taken while it waits.
module bitmap_page_frame_allocator #(
  parameter int unsigned MAX_PAGES  = bpfa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] byte_address_i,
  input  logic [31:0] byte_length_i,
  input  logic [31:0] failure_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] page_address_o,
  output logic [15:0] free_count_o
);

  localparam int unsigned WORDS  = (MAX_PAGES + 31) / 32;
  localparam int unsigned SWORDS = (WORDS + 31) / 32;
  localparam int unsigned WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SAW    = (SWORDS > 1) ? $clog2(SWORDS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int unsigned RW     = 34;
  localparam logic [RW-1:0] MAXP      = RW'(MAX_PAGES);
  localparam logic [RW-1:0] PAGE_MASK = RW'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
  localparam logic [SAW-1:0] LAST_SWORD = SAW'(SWORDS - 1);

  bpfa_pkg::state_e  state_q, state_d;
  bpfa_pkg::action_e act_q;
  bpfa_pkg::status_e status_q, status_d;
  bpfa_pkg::status_e out_status_q;

  logic [31:0]      addr_q, len_q, fcnt_q;
  logic [15:0]      page_total_q;
  logic [31:0]      fail_pend_q, fail_pend_d;
  logic [15:0]      free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [WAW-1:0]   widx_q, widx_d, wlast_q, wlast_d;
  logic [SAW-1:0]   sidx_q, sidx_d;
  logic [WAW-1:0]   clr_q;
  logic [31:0]      paddr_q, paddr_d;
  logic             out_valid_q;
  logic [31:0]      out_paddr_q;
  logic [15:0]      out_cnt_q;

  logic             in_acc, out_load;
  logic [RW-1:0]    tot, first, cnt, span_end, hi_rng, wpage;
  logic [SAW+4:0]   wnum;
  logic [4:0]       sbit;

  logic             bm_we, sum_we;
  logic [WAW-1:0]   bm_addr;
  logic [SAW-1:0]   sum_addr;
  logic [31:0]      bm_wdata, bm_rdata, sum_wdata, sum_rdata, sum_upd;

  bpfa_pkg::mod_req_t mreq;
  bpfa_pkg::mod_res_t mres;

  assign in_ready_o = (state_q == bpfa_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == bpfa_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // effective total and range bounds, all in a common wide format
  always_comb begin
    tot   = (RW'(page_total_q) < MAXP) ? RW'(page_total_q) : MAXP;
    first = RW'(addr_q >> PAGE_SHIFT);
    case (act_q)
      bpfa_pkg::ACT_RELEASE: cnt = RW'(len_q >> PAGE_SHIFT);
      bpfa_pkg::ACT_RESERVE: cnt = (RW'(len_q) + PAGE_MASK) >> PAGE_SHIFT;
      default:               cnt = RW'(1);
    endcase
    span_end = first + cnt;
    hi_rng   = (span_end < tot) ? span_end : tot;
    wnum     = {sidx_q, bpfa_pkg::lowest_set(sum_rdata)};
    wpage    = RW'(wnum) << 5;
  end

  always_comb begin
    mreq.old_word = bm_rdata;
    mreq.lo_bit   = lo_q[4:0];
    mreq.last_bit = 5'(hi_q - CNT_W'(1));
    mreq.is_first = (widx_q == WAW'(lo_q >> 5));
    mreq.is_last  = (widx_q == wlast_q);
    case (act_q)
      bpfa_pkg::ACT_ALLOC:   mreq.op = bpfa_pkg::MOD_ALLOC;
      bpfa_pkg::ACT_RESERVE: mreq.op = bpfa_pkg::MOD_SET;
      default:               mreq.op = bpfa_pkg::MOD_CLR;
    endcase
  end

  bpfa_word_mod u_word_mod (
    .req_i (mreq),
    .res_o (mres)
  );

  // summary bit follows whether the rewritten word still has a free page
  always_comb begin
    sbit    = 5'(widx_q);
    sum_upd = sum_rdata;
    sum_upd[sbit] = ~&mres.new_word;
  end

  always_comb begin
    bm_we     = (state_q == bpfa_pkg::ST_CLEAR) || (state_q == bpfa_pkg::ST_WORD_MOD);
    sum_we    = ((state_q == bpfa_pkg::ST_CLEAR) && (32'(clr_q) < SWORDS)) ||
                (state_q == bpfa_pkg::ST_WORD_MOD);
    bm_addr   = (state_q == bpfa_pkg::ST_CLEAR) ? clr_q : widx_q;
    bm_wdata  = (state_q == bpfa_pkg::ST_CLEAR) ? '1 : mres.new_word;
    sum_wdata = (state_q == bpfa_pkg::ST_CLEAR) ? '0 : sum_upd;
    case (state_q)
      bpfa_pkg::ST_CLEAR:   sum_addr = SAW'(clr_q);
      bpfa_pkg::ST_SRCH_RD: sum_addr = sidx_q;
      default:              sum_addr = SAW'(widx_q >> 5);
    endcase
  end

  bpfa_ram #(.WIDTH(32), .DEPTH(WORDS)) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .addr_i  (bm_addr),
    .wdata_i (bm_wdata),
    .rdata_o (bm_rdata)
  );

  bpfa_ram #(.WIDTH(32), .DEPTH(SWORDS)) u_summary_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .addr_i  (sum_addr),
    .wdata_i (sum_wdata),
    .rdata_o (sum_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        if (clr_q == LAST_WORD) state_d = bpfa_pkg::ST_IDLE;
      end
      bpfa_pkg::ST_IDLE: begin
        if (in_acc) state_d = bpfa_pkg::ST_SETUP;
      end
      bpfa_pkg::ST_SETUP: begin
        case (act_q)
          bpfa_pkg::ACT_ALLOC: begin
            state_d = (fail_pend_q != '0) ? bpfa_pkg::ST_DONE : bpfa_pkg::ST_SRCH_RD;
          end
          bpfa_pkg::ACT_FREE, bpfa_pkg::ACT_RELEASE, bpfa_pkg::ACT_RESERVE: begin
            state_d = (first >= hi_rng) ? bpfa_pkg::ST_DONE : bpfa_pkg::ST_WORD_RD;
          end
          default: state_d = bpfa_pkg::ST_DONE;
        endcase
      end
      bpfa_pkg::ST_SRCH_RD: state_d = bpfa_pkg::ST_SRCH_CHK;
      bpfa_pkg::ST_SRCH_CHK: begin
        if (|sum_rdata) begin
          state_d = (wpage >= tot) ? bpfa_pkg::ST_DONE : bpfa_pkg::ST_WORD_RD;
        end else if (sidx_q == LAST_SWORD) begin
          state_d = bpfa_pkg::ST_DONE;
        end else begin
          state_d = bpfa_pkg::ST_SRCH_RD;
        end
      end
      bpfa_pkg::ST_WORD_RD: state_d = bpfa_pkg::ST_WORD_MOD;
      bpfa_pkg::ST_WORD_MOD: begin
        if (mreq.op != bpfa_pkg::MOD_ALLOC && act_q != bpfa_pkg::ACT_FREE &&
            widx_q != wlast_q) begin
          state_d = bpfa_pkg::ST_WORD_RD;
        end else begin
          state_d = bpfa_pkg::ST_DONE;
        end
      end
      bpfa_pkg::ST_DONE: begin
        if (out_load) state_d = bpfa_pkg::ST_IDLE;
      end
      default: state_d = bpfa_pkg::ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    status_d    = status_q;
    fail_pend_d = fail_pend_q;
    free_cnt_d  = free_cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    widx_d      = widx_q;
    wlast_d     = wlast_q;
    sidx_d      = sidx_q;
    paddr_d     = paddr_q;
    case (state_q)
      bpfa_pkg::ST_SETUP: begin
        status_d = bpfa_pkg::STAT_OK;
        paddr_d  = '0;
        sidx_d   = '0;
        lo_d     = CNT_W'(first);
        hi_d     = CNT_W'(hi_rng);
        widx_d   = WAW'(first >> 5);
        wlast_d  = WAW'((hi_rng - RW'(1)) >> 5);
        case (act_q)
          bpfa_pkg::ACT_ALLOC: begin
            if (fail_pend_q != '0) begin
              fail_pend_d = fail_pend_q - 32'd1;
              status_d    = bpfa_pkg::STAT_INJECTED;
            end else begin
              status_d = bpfa_pkg::STAT_NO_PAGE;
            end
          end
          bpfa_pkg::ACT_FREE: begin
            if (first >= tot) status_d = bpfa_pkg::STAT_FREE_RANGE;
          end
          bpfa_pkg::ACT_SET_FAIL: fail_pend_d = fcnt_q;
          default: ;
        endcase
      end
      bpfa_pkg::ST_SRCH_CHK: begin
        sidx_d  = sidx_q + SAW'(1);
        lo_d    = CNT_W'(wpage);
        hi_d    = CNT_W'(tot);
        widx_d  = WAW'(wnum);
        wlast_d = WAW'((tot - RW'(1)) >> 5);
      end
      bpfa_pkg::ST_WORD_MOD: begin
        widx_d = widx_q + WAW'(1);
        if (mreq.op == bpfa_pkg::MOD_CLR) begin
          free_cnt_d = free_cnt_q + 16'(mres.delta);
        end else begin
          free_cnt_d = free_cnt_q - 16'(mres.delta);
        end
        if (act_q == bpfa_pkg::ACT_FREE && !mres.hit) begin
          status_d = bpfa_pkg::STAT_FREE_UNUSED;
        end
        if (mreq.op == bpfa_pkg::MOD_ALLOC && mres.hit) begin
          status_d = bpfa_pkg::STAT_OK;
          paddr_d  = 32'(RW'({widx_q, mres.bit_idx}) << PAGE_SHIFT);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpfa_pkg::ST_CLEAR;
      clr_q        <= '0;
      page_total_q <= '0;
      fail_pend_q  <= '0;
      free_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fail_pend_q <= fail_pend_d;
      free_cnt_q  <= free_cnt_d;
      if (state_q == bpfa_pkg::ST_CLEAR) clr_q <= clr_q + WAW'(1);
      if (cfg_we_i) page_total_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= bpfa_pkg::action_e'(action_i);
      addr_q <= byte_address_i;
      len_q  <= byte_length_i;
      fcnt_q <= failure_count_i;
    end
    status_q <= status_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    widx_q   <= widx_d;
    wlast_q  <= wlast_d;
    sidx_q   <= sidx_d;
    paddr_q  <= paddr_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_paddr_q  <= paddr_q;
      out_cnt_q    <= free_cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign page_address_o = out_paddr_q;
  assign free_count_o   = out_cnt_q;

endmodule

@@ sv/bpfa_checker.sv @@
// Port-level checker for the page frame allocator, bound to the top level.
`include "bitmap_page_frame_allocator_assert.svh"

module bpfa_checker #(
  parameter int unsigned PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] page_address_o,
  input logic [15:0] free_count_o
);

  `BPFA_ASSERT(a_out_valid_held, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `BPFA_ASSERT_HOLD(a_out_payload_held, out_valid_o && !out_ready_i, {status_o, page_address_o, free_count_o}, "result changed while stalled")
  `BPFA_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o, "request taken while busy")
  `BPFA_ASSERT(a_addr_aligned, out_valid_o |-> (page_address_o[PAGE_SHIFT-1:0] == '0) && (status_o == bpfa_pkg::STAT_OK || page_address_o == 32'd0), "bad page address in result")

endmodule

bind bitmap_page_frame_allocator bpfa_checker #(.PAGE_SHIFT(PAGE_SHIFT)) u_bpfa_checker (.*);

@@ tb/sv/tb_bitmap_page_frame_allocator.sv @@
// Self-checking testbench for the bitmap page frame allocator: directed and random requests.
module tb_bitmap_page_frame_allocator;
  import bpfa_pkg::*;

  localparam int unsigned NUM_PAGES      = MAX_PAGES_DEF;
  localparam int unsigned PG_SHIFT       = PAGE_SHIFT_DEF;
  localparam int unsigned PAGE_BYTES     = 1 << PG_SHIFT;
  localparam int          CLK_PERIOD     = 12;
  localparam int          TAIL_CYCLES    = 100;
  localparam int          TIMEOUT_CYCLES = 2000000;
  localparam int          HOLD_CYCLES    = 200;
  localparam logic [2:0]  ACT_UNUSED_LO  = 3'd5;
  localparam logic [2:0]  ACT_UNUSED_HI  = 3'd7;

  typedef struct packed {
    status_e     status;
    logic [31:0] page_addr;
    logic [15:0] free_cnt;
  } alloc_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  action_i;
  logic [31:0] byte_address_i;
  logic [31:0] byte_length_i;
  logic [31:0] failure_count_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [31:0] page_address_o;
  logic [15:0] free_count_o;

  // allocator state as the block should hold it
  bit          page_used [NUM_PAGES];
  logic [15:0] free_page_tally;
  logic [31:0] fail_credits;
  logic [15:0] page_total_cfg;

  alloc_result_t expected_results[$];
  int unsigned   granted_pages[$];
  int unsigned   mismatch_count;
  bit            steady_flow;
  int            rx_hold_left;

  bitmap_page_frame_allocator #(
    .MAX_PAGES (NUM_PAGES),
    .PAGE_SHIFT(PG_SHIFT)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .byte_address_i (byte_address_i),
    .byte_length_i  (byte_length_i),
    .failure_count_i(failure_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .page_address_o (page_address_o),
    .free_count_o   (free_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("bitmap_page_frame_allocator regression: fail");
    $finish;
  end

  function automatic void reset_allocator_model();
    foreach (page_used[i]) page_used[i] = 1'b1;
    free_page_tally = '0;
    fail_credits    = '0;
    page_total_cfg  = '0;
  endfunction

  function automatic int unsigned eff_page_total();
    return (page_total_cfg < NUM_PAGES) ? page_total_cfg : NUM_PAGES;
  endfunction

  function automatic void set_page_state(input longint unsigned pg, input bit used);
    if (page_used[pg] != used) begin
      page_used[pg] = used;
      free_page_tally = used ? free_page_tally - 16'd1 : free_page_tally + 16'd1;
    end
  endfunction

  function automatic alloc_result_t predict_allocator(input logic [2:0] act,
                                                      input logic [31:0] addr,
                                                      input logic [31:0] len,
                                                      input logic [31:0] fcnt);
    alloc_result_t   r;
    longint unsigned total;
    longint unsigned first_pg;
    longint unsigned n_pages;
    longint unsigned pg;
    r.status    = STAT_OK;
    r.page_addr = '0;
    total       = eff_page_total();
    first_pg    = addr >> PG_SHIFT;
    case (act)
      ACT_ALLOC: begin
        if (fail_credits != 0) begin
          fail_credits = fail_credits - 32'd1;
          r.status = STAT_INJECTED;
        end else begin
          r.status = STAT_NO_PAGE;
          for (pg = 0; pg < total; pg++) begin
            if (!page_used[pg]) begin
              set_page_state(pg, 1'b1);
              r.page_addr = 32'(pg << PG_SHIFT);
              r.status = STAT_OK;
              granted_pages.push_back(32'(pg));
              break;
            end
          end
        end
      end
      ACT_FREE: begin
        if (first_pg >= total) r.status = STAT_FREE_RANGE;
        else if (!page_used[first_pg]) r.status = STAT_FREE_UNUSED;
        else set_page_state(first_pg, 1'b0);
      end
      ACT_RELEASE, ACT_RESERVE: begin
        // release rounds the length down to whole pages, reserve rounds it up
        if (act == ACT_RELEASE) n_pages = 64'(len) >> PG_SHIFT;
        else n_pages = (64'(len) + PAGE_BYTES - 1) >> PG_SHIFT;
        for (pg = first_pg; pg < first_pg + n_pages && pg < total; pg++)
          set_page_state(pg, act == ACT_RESERVE);
      end
      ACT_SET_FAIL: fail_credits = fcnt;
      default: ;
    endcase
    r.free_cnt = free_page_tally;
    return r;
  endfunction

  task automatic send_request(input logic [2:0] act, input logic [31:0] addr,
                              input logic [31:0] len, input logic [31:0] fcnt);
    @(negedge clk_i);
    if (!steady_flow && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 50);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    byte_address_i  <= addr;
    byte_length_i   <= len;
    failure_count_i <= fcnt;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_allocator(act, addr, len, fcnt));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_page_total(input logic [15:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    page_total_cfg = value;
  endtask

  // page_total still at its reset value of zero: nothing can be allocated or freed
  task automatic test_empty_pool();
    send_request(ACT_ALLOC, '0, '0, '0);
    send_request(ACT_FREE, '0, '0, '0);
    send_request(ACT_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_UNUSED_HI, '0, '0, '0);
    send_request(ACT_RELEASE, '0, 32'hFFFF_FFFF, '0);
    send_request(ACT_RESERVE, '0, 32'hFFFF_FFFF, '0);
    drain_results();
  endtask

  task automatic test_basic_ops();
    write_page_total(16'd64);
    send_request(ACT_RELEASE, '0, (32'd64 << PG_SHIFT) | (PAGE_BYTES - 1), '0);
    send_request(ACT_ALLOC, '0, '0, '0);
    send_request(ACT_ALLOC, '0, '0, '0);
    send_request(ACT_FREE, 32'h0000_0ABC, '0, '0);
    send_request(ACT_FREE, 32'h0000_0123, '0, '0);
    send_request(ACT_RESERVE, 32'h0000_3000, 32'd1, '0);
    send_request(ACT_RESERVE, 32'h0000_5000, '0, '0);
    // range running past the total, its pages already free
    send_request(ACT_RELEASE, 32'd60 << PG_SHIFT, 32'hFFFF_FFFF, '0);
    send_request(ACT_FREE, 32'hFFFF_FFFF, '0, '0);
    send_request(ACT_FREE, 32'd64 << PG_SHIFT, '0, '0);
    drain_results();
  endtask

  task automatic test_injected_failures();
    send_request(ACT_SET_FAIL, '0, '0, 32'd2);
    send_request(ACT_ALLOC, '0, '0, '0);
    send_request(ACT_ALLOC, '0, '0, '0);
    send_request(ACT_ALLOC, '0, '0, '0);
    send_request(ACT_SET_FAIL, '0, '0, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC, '0, '0, '0);
    send_request(ACT_SET_FAIL, '0, '0, '0);
    send_request(ACT_RESERVE, '0, 32'hFFFF_FFFF, '0);
    send_request(ACT_ALLOC, '0, '0, '0);
    drain_results();
  endtask

  // pages freed above a smaller total stay counted but are never handed out
  task automatic test_shrink_total();
    send_request(ACT_RELEASE, '0, 32'd64 << PG_SHIFT, '0);
    write_page_total(16'd16);
    send_request(ACT_ALLOC, '0, '0, '0);
    send_request(ACT_FREE, 32'd20 << PG_SHIFT, '0, '0);
    send_request(ACT_RESERVE, '0, 32'd64 << PG_SHIFT, '0);
    send_request(ACT_ALLOC, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_full_capacity();
    write_page_total(16'hFFFF);
    send_request(ACT_RELEASE, '0, 32'hFFFF_FFFF, '0);
    send_request(ACT_ALLOC, '0, '0, '0);
    send_request(ACT_RESERVE, '0, 32'hFFFF_FFFF, '0);
    write_page_total(16'd32768);
    send_request(ACT_ALLOC, '0, '0, '0);
    drain_results();
  endtask

  task automatic run_random_traffic(input logic [15:0] total_cfg, input int n_items,
                                    input bit steady);
    int unsigned tot;
    int unsigned pg;
    int unsigned n_pg;
    int unsigned pick;
    int unsigned idx;
    logic [2:0]  act;
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] fcnt;
    write_page_total(total_cfg);
    steady_flow = steady;
    repeat (n_items) begin
      tot  = eff_page_total();
      pick = $urandom_range(99);
      act  = ACT_ALLOC;
      addr = $urandom;
      len  = $urandom;
      fcnt = $urandom;
      if (pick < 40) begin
        act = ACT_ALLOC;
      end else if (pick < 64) begin
        act = ACT_FREE;
        if (pick < 62) begin
          // half the time give back a page handed out earlier, else any page near the total
          if (granted_pages.size() != 0 && $urandom_range(1) == 1) begin
            idx = $urandom_range(granted_pages.size() - 1);
            pg  = granted_pages[idx];
            granted_pages.delete(idx);
          end else begin
            pg = $urandom_range(tot + tot / 8 + 1);
          end
          addr = (pg << PG_SHIFT) | $urandom_range(PAGE_BYTES - 1);
        end
      end else if (pick < 84) begin
        act  = (pick < 74) ? ACT_RELEASE : ACT_RESERVE;
        pg   = $urandom_range(tot);
        n_pg = $urandom_range(40);
        addr = (pg << PG_SHIFT) | $urandom_range(PAGE_BYTES - 1);
        len  = (n_pg << PG_SHIFT) | $urandom_range(PAGE_BYTES - 1);
      end else if (pick < 87) begin
        act = $urandom_range(1) ? ACT_RELEASE : ACT_RESERVE;
      end else if (pick < 91) begin
        act  = ACT_SET_FAIL;
        fcnt = $urandom_range(3);
      end else if (pick < 92) begin
        // random full-width failure count, one allocate, then back to a small count
        send_request(ACT_SET_FAIL, $urandom, $urandom, $urandom);
        send_request(ACT_ALLOC, $urandom, $urandom, $urandom);
        act  = ACT_SET_FAIL;
        fcnt = $urandom_range(1);
      end else if (pick < 95) begin
        act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
      send_request(act, addr, len, fcnt);
    end
    drain_results();
    steady_flow = 1'b0;
  endtask

  // result side stalls long enough for the request side to back up
  task automatic test_backpressure();
    steady_flow  = 1'b1;
    rx_hold_left = HOLD_CYCLES;
    repeat (8) begin
      send_request(ACT_ALLOC, $urandom, $urandom, $urandom);
      send_request(ACT_FREE, $urandom_range(eff_page_total()) << PG_SHIFT, $urandom, $urandom);
    end
    drain_results();
    steady_flow = 1'b0;
  endtask

  // result side: random stalls, long hold-offs on request, none in steady phases
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else if (steady_flow) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 33);
      end
    end
  end

  initial begin
    alloc_result_t exp_res;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result status %0d page_address %h free_count %0d",
                   $time, status_o, page_address_o, free_count_o);
        end else begin
          exp_res = expected_results.pop_front();
          if (status_o !== exp_res.status) begin
            mismatch_count++;
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status_o);
          end
          if (page_address_o !== exp_res.page_addr) begin
            mismatch_count++;
            $display("%0t: page_address expected %h actual %h", $time, exp_res.page_addr,
                     page_address_o);
          end
          if (free_count_o !== exp_res.free_cnt) begin
            mismatch_count++;
            $display("%0t: free_count expected %0d actual %0d", $time, exp_res.free_cnt,
                     free_count_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    action_i        = ACT_ALLOC;
    byte_address_i  = '0;
    byte_length_i   = '0;
    failure_count_i = '0;
    steady_flow     = 1'b0;
    rx_hold_left    = 0;
    mismatch_count  = 0;
    reset_allocator_model();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_pool();
    test_basic_ops();
    test_injected_failures();
    test_shrink_total();
    test_full_capacity();
    run_random_traffic(16'd37, 110, 1'b0);
    run_random_traffic(16'd100, 110, 1'b0);
    test_backpressure();
    run_random_traffic(16'd2000, 120, 1'b1);
    run_random_traffic(16'd32768, 110, 1'b0);
    run_random_traffic(16'hFFFF, 90, 1'b0);
    run_random_traffic(16'd1, 40, 1'b0);
    run_random_traffic(16'd0, 20, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("bitmap_page_frame_allocator regression: pass");
    end else begin
      $display("bitmap_page_frame_allocator regression: fail");
    end
    $finish;
  end

endmodule
